// ===== hw/rtl/mbg_pkg.sv =====
// Shared types and constants for the button-grid LED bridge.
// No dependencies; the front end, command queue, back end, top level and bench import this package.
`timescale 1ns / 1ps

package mbg_pkg;

  localparam logic [7:0] NOTE_STATUS = 8'h90;
  localparam logic [7:0] CTRL_STATUS = 8'hB0;
  localparam int unsigned NUM_BUTTONS = 80;

  // Command kinds produced by the front end.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_GRID,
    CMD_RIGHT,
    CMD_TOP,
    CMD_COLOR
  } cmd_kind_e;

  // One classified item on its way from the front end to the back end.
  typedef struct packed {
    cmd_kind_e   kind;
    logic        set;     // pressed (1) or released (0)
    logic [5:0]  pos;     // bitmap position; low three bits for right and top
    logic [6:0]  idx;     // button index of a color command
    logic [5:0]  color;   // red | green << 4
    logic [7:0]  status;  // packet status byte of a color command
    logic [6:0]  key;     // packet key byte of a color command
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_status;
    logic [6:0]  send_key;
    logic [5:0]  send_value;
    logic [63:0] grid_pressed;
    logic [7:0]  right_pressed;
    logic [7:0]  top_pressed;
  } res_t;

endpackage

// ===== hw/rtl/mbg_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
// Depends on nothing; used by the top level of the bridge.
`timescale 1ns / 1ps

interface mbg_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] midi_status;
  logic [7:0] midi_key;
  logic [7:0] midi_value;
  logic [6:0] button_index;
  logic [1:0] red_level;
  logic [1:0] green_level;

  modport source (output valid, action, midi_status, midi_key, midi_value,
                  button_index, red_level, green_level, input ready);
  modport sink (input valid, action, midi_status, midi_key, midi_value,
                button_index, red_level, green_level, output ready);
endinterface

interface mbg_out_if;
  logic        valid;
  logic        ready;
  logic        send_valid;
  logic [7:0]  send_status;
  logic [6:0]  send_key;
  logic [5:0]  send_value;
  logic [63:0] grid_pressed;
  logic [7:0]  right_pressed;
  logic [7:0]  top_pressed;

  modport source (output valid, send_valid, send_status, send_key, send_value,
                  grid_pressed, right_pressed, top_pressed, input ready);
  modport sink (input valid, send_valid, send_status, send_key, send_value,
                grid_pressed, right_pressed, top_pressed, output ready);
endinterface

// ===== hw/rtl/mbg_front.sv =====
// Front end: decodes a raw item into a command for the back end.
// Depends on mbg_pkg.
`timescale 1ns / 1ps

module mbg_front
  import mbg_pkg::*;
(
  input  logic       action_i,
  input  logic [7:0] midi_status_i,
  input  logic [7:0] midi_key_i,
  input  logic [7:0] midi_value_i,
  input  logic [6:0] button_index_i,
  input  logic [1:0] red_level_i,
  input  logic [1:0] green_level_i,
  output cmd_t       cmd_o
);

  always_comb begin
    cmd_o        = '0;
    cmd_o.kind   = CMD_NONE;
    cmd_o.set    = (midi_value_i != 8'd0);
    cmd_o.idx    = button_index_i;
    cmd_o.color  = {green_level_i, 2'b00, red_level_i};
    if (!action_i) begin
      if (midi_status_i == NOTE_STATUS && !midi_key_i[7] && !midi_key_i[3]) begin
        cmd_o.kind = CMD_GRID;
        cmd_o.pos  = {midi_key_i[6:4], midi_key_i[2:0]};
      end else if (midi_status_i == NOTE_STATUS && !midi_key_i[7]
                   && midi_key_i[3:0] == 4'h8) begin
        cmd_o.kind = CMD_RIGHT;
        cmd_o.pos  = {3'd0, midi_key_i[6:4]};
      end else if (midi_status_i == CTRL_STATUS && midi_key_i[7:3] == 5'b01101) begin
        cmd_o.kind = CMD_TOP;
        cmd_o.pos  = {3'd0, midi_key_i[2:0]};
      end
    end else begin
      // Grid buttons sit below 64, then eight right rows, then eight top columns.
      if (!button_index_i[6]) begin
        cmd_o.kind   = CMD_COLOR;
        cmd_o.status = NOTE_STATUS;
        cmd_o.key    = {button_index_i[5:3], 1'b0, button_index_i[2:0]};
      end else if (button_index_i[5:3] == 3'b000) begin
        cmd_o.kind   = CMD_COLOR;
        cmd_o.status = NOTE_STATUS;
        cmd_o.key    = {button_index_i[2:0], 4'b1000};
      end else if (button_index_i[5:3] == 3'b001) begin
        cmd_o.kind   = CMD_COLOR;
        cmd_o.status = CTRL_STATUS;
        cmd_o.key    = {4'b1101, button_index_i[2:0]};
      end
    end
  end

endmodule

// ===== hw/rtl/mbg_cmd_fifo.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on mbg_pkg for the command type.
`timescale 1ns / 1ps

module mbg_cmd_fifo
  import mbg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_data_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = entry_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// ===== hw/rtl/mbg_back.sv =====
// Back end: color cache lookup, pressed bitmaps and the result register.
// Depends on mbg_pkg for the command and result types.
`timescale 1ns / 1ps

module mbg_back
  import mbg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  // Last color sent per button; entries never written read as zero.
  logic [5:0]             sent_mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] sent_vld_q;
  logic [5:0]             rdata_q;
  logic                   fwd_hit_q;
  logic [5:0]             fwd_color_q;

  cmd_t        b_q;
  logic        b_valid_q;
  logic [63:0] grid_q, grid_d;
  logic [7:0]  right_q, right_d, top_q, top_d;
  res_t        res_q;
  logic        res_valid_q;

  logic        b_adv, pop, change;
  logic [5:0]  old_color;

  assign b_adv       = b_valid_q && (!res_valid_q || res_ready_i);
  assign cmd_ready_o = !b_valid_q || b_adv;
  assign pop         = cmd_valid_i && cmd_ready_o;

  always_comb begin
    if (fwd_hit_q) old_color = fwd_color_q;
    else if (sent_vld_q[b_q.idx]) old_color = rdata_q;
    else old_color = 6'd0;
    change = (b_q.kind == CMD_COLOR) && (old_color != b_q.color);

    grid_d  = grid_q;
    right_d = right_q;
    top_d   = top_q;
    case (b_q.kind)
      CMD_GRID:  grid_d[b_q.pos] = b_q.set;
      CMD_RIGHT: right_d[b_q.pos[2:0]] = b_q.set;
      CMD_TOP:   top_d[b_q.pos[2:0]] = b_q.set;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      res_valid_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
      sent_vld_q  <= '0;
      grid_q      <= '0;
      right_q     <= '0;
      top_q       <= '0;
    end else begin
      if (pop) begin
        b_valid_q <= 1'b1;
        fwd_hit_q <= b_adv && change && (cmd_i.idx == b_q.idx);
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        res_valid_q <= 1'b1;
        grid_q      <= grid_d;
        right_q     <= right_d;
        top_q       <= top_d;
        if (change) sent_vld_q[b_q.idx] <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b_q         <= cmd_i;
      fwd_color_q <= b_q.color;
      if (cmd_i.kind == CMD_COLOR) rdata_q <= sent_mem[cmd_i.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && change) sent_mem[b_q.idx] <= b_q.color;
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      res_q.send_valid    <= change;
      res_q.send_status   <= change ? b_q.status : 8'd0;
      res_q.send_key      <= change ? b_q.key : 7'd0;
      res_q.send_value    <= change ? b_q.color : 6'd0;
      res_q.grid_pressed  <= grid_d;
      res_q.right_pressed <= right_d;
      res_q.top_pressed   <= top_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/midi_button_grid_led_bridge.sv =====
// Top level of the button-grid LED bridge.
// Depends on mbg_pkg, mbg_if, mbg_front, mbg_cmd_fifo and mbg_back.
`timescale 1ns / 1ps

// The bridge takes one item per transfer on in_i and returns exactly one
// result per item on res_o, in order. A MIDI item (action 0) updates the grid,
// right-column or top-row pressed bitmaps; a color item (action 1) produces a
// packet only when the color differs from the last one sent to that button.
// Every result carries the bitmaps as they stand after its own item. The block
// sustains one item per clock while results are taken: an accepted item is
// decoded and written into the queue, moves into the back-end stage register
// while the 80-entry color cache is read, and then lands in the result
// register. The queue holds two items, which lets the input keep moving while
// a result waits to be taken. The color cache clears at reset through
// per-entry valid flops, so the block is ready out of reset with no clearing
// pass.

module midi_button_grid_led_bridge
  import mbg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  mbg_in_if.sink   in_i,
  mbg_out_if.source res_o
);

  cmd_t front_cmd, head_cmd;
  logic head_valid, head_ready;
  res_t res;

  // Decode the raw item into a command.
  mbg_front u_front (
    .action_i       (in_i.action),
    .midi_status_i  (in_i.midi_status),
    .midi_key_i     (in_i.midi_key),
    .midi_value_i   (in_i.midi_value),
    .button_index_i (in_i.button_index),
    .red_level_i    (in_i.red_level),
    .green_level_i  (in_i.green_level),
    .cmd_o          (front_cmd)
  );

  // Short queue so the input side does not wait on a briefly stalled result.
  mbg_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (in_i.valid),
    .wr_ready_o (in_i.ready),
    .wr_data_i  (front_cmd),
    .rd_valid_o (head_valid),
    .rd_ready_i (head_ready),
    .rd_data_o  (head_cmd)
  );

  // Cache compare, bitmap update and the result register.
  mbg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_ready_o (head_ready),
    .cmd_i       (head_cmd),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign res_o.send_valid    = res.send_valid;
  assign res_o.send_status   = res.send_status;
  assign res_o.send_key      = res.send_key;
  assign res_o.send_value    = res.send_value;
  assign res_o.grid_pressed  = res.grid_pressed;
  assign res_o.right_pressed = res.right_pressed;
  assign res_o.top_pressed   = res.top_pressed;

  // A packet always carries a note or a control status.
  a_pkt_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.send_valid |->
      (res_o.send_status == NOTE_STATUS || res_o.send_status == CTRL_STATUS))
    else $error("packet with unexpected status byte");

  // Without a packet the packet fields are all zero.
  a_no_pkt_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.send_valid |->
      (res_o.send_status == 8'd0 && res_o.send_key == 7'd0 && res_o.send_value == 6'd0))
    else $error("packet fields not cleared without a packet");

  // A control packet addresses a top button.
  a_top_key : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.send_valid && res_o.send_status == CTRL_STATUS |->
      res_o.send_key[6:3] == 4'b1101)
    else $error("control packet with a key outside the top row");

endmodule

// ===== bench/midi_button_grid_led_bridge_test.sv =====
// Self-checking regression for midi_button_grid_led_bridge: directed table plus random traffic.
// Depends on mbg_pkg, the mbg_in_if and mbg_out_if interfaces and the bridge RTL.
`timescale 1ns / 1ps

module midi_button_grid_led_bridge_test;
  import mbg_pkg::*;

  // Action codes of an input item.
  localparam logic ACT_MIDI  = 1'b0;
  localparam logic ACT_COLOR = 1'b1;

  // Key patterns that route a received message to one of the three bitmaps.
  localparam logic [7:0] GRID_KEY_MASK  = 8'h88;
  localparam logic [7:0] GRID_KEY_TAG   = 8'h00;
  localparam logic [7:0] RIGHT_KEY_MASK = 8'h8f;
  localparam logic [7:0] RIGHT_KEY_TAG  = 8'h08;
  localparam logic [7:0] TOP_KEY_MASK   = 8'hf8;
  localparam logic [7:0] TOP_KEY_TAG    = 8'h68;

  localparam int NUM_GRID        = 64;
  localparam int NUM_GRID_RIGHT  = 72;
  localparam int RANDOM_ITEMS    = 1825;
  localparam int CALM_ITEMS      = 250;
  localparam int HOLD_AT_ITEM    = 600;
  localparam int DRAIN_AT_ITEM   = 1200;
  localparam int HOLD_CYCLES     = 48;
  localparam int TAIL_CYCLES     = 8;
  localparam int WATCHDOG_CYCLES = 1000;

  localparam logic [63:0] GRID_TOP_LEFT = 64'h8000_0000_0000_0000;

  // One input item as the sender sees it.
  typedef struct packed {
    logic       action;
    logic [7:0] midi_status;
    logic [7:0] midi_key;
    logic [7:0] midi_value;
    logic [6:0] button_index;
    logic [1:0] red_level;
    logic [1:0] green_level;
  } bridge_item_t;

  // One row of the directed table; pinned rows carry a hand-written result.
  typedef struct packed {
    bridge_item_t item;
    logic         pinned;
    res_t         want;
  } plan_row_t;

  logic clk;
  logic rst_n;

  mbg_in_if  item_bus ();
  mbg_out_if result_bus ();

  midi_button_grid_led_bridge u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (item_bus.sink),
    .res_o (result_bus.source)
  );

  // Pinned expectation that travels alongside the item currently on offer.
  logic drv_pinned;
  res_t drv_pinned_res;

  // Shadow of the bridge state used to work out every expected result.
  logic [63:0] grid_bits;
  logic [7:0]  right_bits;
  logic [7:0]  top_bits;
  logic [5:0]  sent_color [NUM_BUTTONS];

  res_t      result_q [$];
  plan_row_t plan_q [$];

  bit calm;
  bit hold_req;
  int mismatches;
  int items_taken;
  int results_checked;
  int bitmap_updates;
  int packets_sent;
  int ignored_items;
  int idle_cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Updates the shadow state with one accepted item and returns the result that the
  // bridge must produce for it. Bitmaps are taken after the update.
  function automatic res_t bridge_predict(bridge_item_t it);
    res_t       r;
    logic       set;
    logic [5:0] color;
    logic [6:0] idx;
    r     = '0;
    set   = it.midi_value != 8'd0;
    color = {it.green_level, 2'b00, it.red_level};
    idx   = it.button_index;
    if (it.action == ACT_MIDI) begin
      if (it.midi_status == NOTE_STATUS && (it.midi_key & GRID_KEY_MASK) == GRID_KEY_TAG) begin
        grid_bits[{it.midi_key[6:4], it.midi_key[2:0]}] = set;
        bitmap_updates++;
      end else if (it.midi_status == NOTE_STATUS &&
                   (it.midi_key & RIGHT_KEY_MASK) == RIGHT_KEY_TAG) begin
        right_bits[it.midi_key[6:4]] = set;
        bitmap_updates++;
      end else if (it.midi_status == CTRL_STATUS &&
                   (it.midi_key & TOP_KEY_MASK) == TOP_KEY_TAG) begin
        top_bits[it.midi_key[2:0]] = set;
        bitmap_updates++;
      end else begin
        ignored_items++;
      end
    end else if (idx < NUM_BUTTONS && sent_color[idx] != color) begin
      // Only a change of color is worth a packet; the cache starts all dark.
      sent_color[idx] = color;
      r.send_valid    = 1'b1;
      r.send_value    = color;
      packets_sent++;
      if (idx < NUM_GRID) begin
        r.send_status = NOTE_STATUS;
        r.send_key    = {idx[5:3], 1'b0, idx[2:0]};
      end else if (idx < NUM_GRID_RIGHT) begin
        r.send_status = NOTE_STATUS;
        r.send_key    = {idx[2:0], RIGHT_KEY_TAG[3:0]};
      end else begin
        r.send_status = CTRL_STATUS;
        r.send_key    = {TOP_KEY_TAG[6:3], idx[2:0]};
      end
    end else begin
      // Repeated color or an index past the last button.
      ignored_items++;
    end
    r.grid_pressed  = grid_bits;
    r.right_pressed = right_bits;
    r.top_pressed   = top_bits;
    return r;
  endfunction

  function automatic res_t res_of(logic sv, logic [7:0] st, logic [6:0] key, logic [5:0] val,
                                  logic [63:0] grid, logic [7:0] right, logic [7:0] top);
    res_t r;
    r = '{sv, st, key, val, grid, right, top};
    return r;
  endfunction

  task automatic add_row(logic act, logic [7:0] st, logic [7:0] key, logic [7:0] val,
                         logic [6:0] idx, logic [1:0] red, logic [1:0] green,
                         logic pinned, res_t want);
    plan_row_t row;
    row.item   = '{act, st, key, val, idx, red, green};
    row.pinned = pinned;
    row.want   = want;
    plan_q.push_back(row);
  endtask

  // Random traffic is mostly well-formed: color requests for real buttons and
  // MIDI messages that hit one of the three bitmaps. About one item in ten is noise.
  function automatic bridge_item_t random_item();
    bridge_item_t it;
    int           pick;
    it.action       = 1'($urandom_range(0, 1));
    it.midi_status  = 8'($urandom_range(0, 255));
    it.midi_key     = 8'($urandom_range(0, 255));
    it.midi_value   = 8'($urandom_range(0, 255));
    it.button_index = 7'($urandom_range(0, 127));
    it.red_level    = 2'($urandom_range(0, 3));
    it.green_level  = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.action = ACT_COLOR;
      if ($urandom_range(0, 9) != 0) it.button_index = 7'($urandom_range(0, NUM_BUTTONS - 1));
      else it.button_index = 7'($urandom_range(NUM_BUTTONS, 127));
      // A narrow palette makes repeated colors, and so suppressed packets, common.
      if ($urandom_range(0, 1) != 0) begin
        it.red_level   = ($urandom_range(0, 1) != 0) ? 2'd3 : 2'd0;
        it.green_level = ($urandom_range(0, 1) != 0) ? 2'd3 : 2'd0;
      end
    end else if (pick < 90) begin
      it.action     = ACT_MIDI;
      it.midi_value = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(1, 255));
      case ($urandom_range(0, 2))
        0: begin
          it.midi_status = NOTE_STATUS;
          it.midi_key    = {1'b0, 3'($urandom_range(0, 7)), 1'b0, 3'($urandom_range(0, 7))};
        end
        1: begin
          it.midi_status = NOTE_STATUS;
          it.midi_key    = {1'b0, 3'($urandom_range(0, 7)), RIGHT_KEY_TAG[3:0]};
        end
        default: begin
          it.midi_status = CTRL_STATUS;
          it.midi_key    = {TOP_KEY_TAG[7:3], 3'($urandom_range(0, 7))};
        end
      endcase
    end
    return it;
  endfunction

  // Called at a rising edge. Optionally idles first, then offers the item and
  // returns at the edge where the transfer takes place.
  task automatic offer_item(bridge_item_t it, logic pinned, res_t want);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid        <= 1'b1;
    item_bus.action       <= it.action;
    item_bus.midi_status  <= it.midi_status;
    item_bus.midi_key     <= it.midi_key;
    item_bus.midi_value   <= it.midi_value;
    item_bus.button_index <= it.button_index;
    item_bus.red_level    <= it.red_level;
    item_bus.green_level  <= it.green_level;
    drv_pinned            <= pinned;
    drv_pinned_res        <= want;
    do @(posedge clk); while (!item_bus.ready);
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result side. Ready drops in short random bursts, once for a long hold-off
  // while the sender keeps pushing, and never during the calm tail of the run.
  initial begin
    int stall_left;
    stall_left = 0;
    result_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        result_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 6);
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Monitor: every accepted item is run through the predictor at the edge of its
  // transfer, and every accepted result is checked against the oldest expectation.
  // The watchdog counts edges on which neither side moves a transfer.
  always @(posedge clk) begin
    bridge_item_t it;
    res_t         want;
    res_t         got;
    if (rst_n) begin
      idle_cycles++;
      if (item_bus.valid && item_bus.ready) begin
        it   = '{item_bus.action, item_bus.midi_status, item_bus.midi_key,
                 item_bus.midi_value, item_bus.button_index, item_bus.red_level,
                 item_bus.green_level};
        want = bridge_predict(it);
        // A directed row with a hand-written result replaces the predicted one.
        if (drv_pinned) want = drv_pinned_res;
        result_q.push_back(want);
        items_taken++;
        idle_cycles = 0;
      end
      if (result_bus.valid && result_bus.ready) begin
        idle_cycles = 0;
        if (result_q.size() == 0) begin
          $error("result transfer with no expectation waiting");
          mismatches++;
        end else begin
          want = result_q.pop_front();
          got  = '{result_bus.send_valid, result_bus.send_status, result_bus.send_key,
                   result_bus.send_value, result_bus.grid_pressed,
                   result_bus.right_pressed, result_bus.top_pressed};
          compare_field("send_valid", 64'(want.send_valid), 64'(got.send_valid));
          compare_field("send_status", 64'(want.send_status), 64'(got.send_status));
          compare_field("send_key", 64'(want.send_key), 64'(got.send_key));
          compare_field("send_value", 64'(want.send_value), 64'(got.send_value));
          compare_field("grid_pressed", want.grid_pressed, got.grid_pressed);
          compare_field("right_pressed", 64'(want.right_pressed), 64'(got.right_pressed));
          compare_field("top_pressed", 64'(want.top_pressed), 64'(got.top_pressed));
          results_checked++;
        end
      end
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_CYCLES, result_q.size());
        $display("midi_button_grid_led_bridge regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int   n;
    res_t none;
    none = '0;
    grid_bits  = '0;
    right_bits = '0;
    top_bits   = '0;
    foreach (sent_color[i]) sent_color[i] = '0;
    rst_n = 1'b0;
    item_bus.valid        <= 1'b0;
    item_bus.action       <= ACT_MIDI;
    item_bus.midi_status  <= '0;
    item_bus.midi_key     <= '0;
    item_bus.midi_value   <= '0;
    item_bus.button_index <= '0;
    item_bus.red_level    <= '0;
    item_bus.green_level  <= '0;
    drv_pinned            <= 1'b0;
    drv_pinned_res        <= '0;

    // Directed table. Bitmap corners first, then a release and the messages that must
    // be ignored, then a color for each corner of each button group, then the rest.
    add_row(ACT_MIDI, NOTE_STATUS, 8'h00, 8'h7f, 7'd0, 2'd0, 2'd0, 1'b1,
            res_of(1'b0, 8'h00, 7'h00, 6'h00, 64'h1, 8'h00, 8'h00));
    add_row(ACT_MIDI, NOTE_STATUS, 8'h77, 8'hff, 7'd0, 2'd0, 2'd0, 1'b1,
            res_of(1'b0, 8'h00, 7'h00, 6'h00, GRID_TOP_LEFT | 64'h1, 8'h00, 8'h00));
    add_row(ACT_MIDI, NOTE_STATUS, 8'h08, 8'h01, 7'd0, 2'd0, 2'd0, 1'b1,
            res_of(1'b0, 8'h00, 7'h00, 6'h00, GRID_TOP_LEFT | 64'h1, 8'h01, 8'h00));
    add_row(ACT_MIDI, NOTE_STATUS, 8'h78, 8'h80, 7'd0, 2'd0, 2'd0, 1'b1,
            res_of(1'b0, 8'h00, 7'h00, 6'h00, GRID_TOP_LEFT | 64'h1, 8'h81, 8'h00));
    add_row(ACT_MIDI, CTRL_STATUS, 8'h68, 8'h40, 7'd0, 2'd0, 2'd0, 1'b1,
            res_of(1'b0, 8'h00, 7'h00, 6'h00, GRID_TOP_LEFT | 64'h1, 8'h81, 8'h01));
    add_row(ACT_MIDI, CTRL_STATUS, 8'h6f, 8'h01, 7'd0, 2'd0, 2'd0, 1'b1,
            res_of(1'b0, 8'h00, 7'h00, 6'h00, GRID_TOP_LEFT | 64'h1, 8'h81, 8'h81));
    // Zero velocity releases.
    add_row(ACT_MIDI, NOTE_STATUS, 8'h00, 8'h00, 7'd0, 2'd0, 2'd0, 1'b1,
            res_of(1'b0, 8'h00, 7'h00, 6'h00, GRID_TOP_LEFT, 8'h81, 8'h81));
    // Unrecognized status, bad grid key, bad top key, all-ones noise.
    add_row(ACT_MIDI, 8'h80, 8'h11, 8'h7f, 7'd0, 2'd0, 2'd0, 1'b1,
            res_of(1'b0, 8'h00, 7'h00, 6'h00, GRID_TOP_LEFT, 8'h81, 8'h81));
    add_row(ACT_MIDI, NOTE_STATUS, 8'h88, 8'hff, 7'd0, 2'd0, 2'd0, 1'b1,
            res_of(1'b0, 8'h00, 7'h00, 6'h00, GRID_TOP_LEFT, 8'h81, 8'h81));
    add_row(ACT_MIDI, CTRL_STATUS, 8'h70, 8'h05, 7'd0, 2'd0, 2'd0, 1'b1,
            res_of(1'b0, 8'h00, 7'h00, 6'h00, GRID_TOP_LEFT, 8'h81, 8'h81));
    add_row(ACT_MIDI, 8'hff, 8'hff, 8'hff, 7'h7f, 2'd3, 2'd3, 1'b1,
            res_of(1'b0, 8'h00, 7'h00, 6'h00, GRID_TOP_LEFT, 8'h81, 8'h81));
    // First color for a button goes out, the same color again does not.
    add_row(ACT_COLOR, 8'h00, 8'h00, 8'h00, 7'd0, 2'd3, 2'd3, 1'b1,
            res_of(1'b1, NOTE_STATUS, 7'h00, 6'h33, GRID_TOP_LEFT, 8'h81, 8'h81));
    add_row(ACT_COLOR, 8'h00, 8'h00, 8'h00, 7'd0, 2'd3, 2'd3, 1'b1,
            res_of(1'b0, 8'h00, 7'h00, 6'h00, GRID_TOP_LEFT, 8'h81, 8'h81));
    add_row(ACT_COLOR, 8'h00, 8'h00, 8'h00, 7'd63, 2'd1, 2'd2, 1'b1,
            res_of(1'b1, NOTE_STATUS, 7'h77, 6'h21, GRID_TOP_LEFT, 8'h81, 8'h81));
    add_row(ACT_COLOR, 8'h00, 8'h00, 8'h00, 7'd64, 2'd2, 2'd0, 1'b1,
            res_of(1'b1, NOTE_STATUS, 7'h08, 6'h02, GRID_TOP_LEFT, 8'h81, 8'h81));
    add_row(ACT_COLOR, 8'h00, 8'h00, 8'h00, 7'd71, 2'd0, 2'd1, 1'b1,
            res_of(1'b1, NOTE_STATUS, 7'h78, 6'h10, GRID_TOP_LEFT, 8'h81, 8'h81));
    add_row(ACT_COLOR, 8'h00, 8'h00, 8'h00, 7'd72, 2'd3, 2'd0, 1'b1,
            res_of(1'b1, CTRL_STATUS, 7'h68, 6'h03, GRID_TOP_LEFT, 8'h81, 8'h81));
    add_row(ACT_COLOR, 8'h00, 8'h00, 8'h00, 7'd79, 2'd0, 2'd3, 1'b1,
            res_of(1'b1, CTRL_STATUS, 7'h6f, 6'h30, GRID_TOP_LEFT, 8'h81, 8'h81));
    // Indexes past the last button are dropped; unused MIDI fields do not matter.
    add_row(ACT_COLOR, 8'h00, 8'h00, 8'h00, 7'd80, 2'd3, 2'd3, 1'b1,
            res_of(1'b0, 8'h00, 7'h00, 6'h00, GRID_TOP_LEFT, 8'h81, 8'h81));
    add_row(ACT_COLOR, 8'hff, 8'hff, 8'hff, 7'd127, 2'd3, 2'd3, 1'b1,
            res_of(1'b0, 8'h00, 7'h00, 6'h00, GRID_TOP_LEFT, 8'h81, 8'h81));
    // Black on a button that was never lit matches the cleared cache.
    add_row(ACT_COLOR, 8'h00, 8'h00, 8'h00, 7'd5, 2'd0, 2'd0, 1'b1,
            res_of(1'b0, 8'h00, 7'h00, 6'h00, GRID_TOP_LEFT, 8'h81, 8'h81));
    // Switching a lit button back off, and releasing three of the corners still held.
    add_row(ACT_COLOR, 8'h00, 8'h00, 8'h00, 7'd0, 2'd0, 2'd0, 1'b0, none);
    add_row(ACT_MIDI, NOTE_STATUS, 8'h77, 8'h00, 7'd0, 2'd0, 2'd0, 1'b0, none);
    add_row(ACT_MIDI, CTRL_STATUS, 8'h6f, 8'h00, 7'd0, 2'd0, 2'd0, 1'b0, none);
    add_row(ACT_MIDI, NOTE_STATUS, 8'h78, 8'h00, 7'd0, 2'd0, 2'd0, 1'b0, none);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan_q[i]) offer_item(plan_q[i].item, plan_q[i].pinned, plan_q[i].want);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // Long receiver hold-off: the sender keeps offering until the input stalls.
      if (n == HOLD_AT_ITEM) hold_req = 1'b1;
      // Sender pause: let every outstanding result drain before going on.
      if (n == DRAIN_AT_ITEM) begin
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (result_q.size() != 0) @(posedge clk);
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      offer_item(random_item(), 1'b0, none);
    end

    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    // Keep the clock running so that any stray extra result is caught by the monitor.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d transfers in: %0d bitmap updates, %0d color packets, %0d ignored.",
             items_taken, bitmap_updates, packets_sent, ignored_items);
    $display("Checked %0d results with %0d field mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("midi_button_grid_led_bridge regression: pass");
    end else begin
      $display("midi_button_grid_led_bridge regression: fail");
    end
    $finish;
  end

endmodule
